// ----- rtl/core/pida_pkg.sv -----
// ----------------------------------------------------------------------------
// pida_pkg - shared definitions for the positional insert/delete array
// Sizes, action and status codes, and the command struct that is broadcast
// to every cell of the chain.
// ----------------------------------------------------------------------------
package pida_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned DataW    = 32;
  localparam int unsigned PosW     = 7;
  localparam int unsigned ActW     = 2;
  localparam int unsigned StatW    = 2;
  localparam int unsigned IdxW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // action codes
  localparam logic [ActW-1:0] ACT_INS  = 2'd0;
  localparam logic [ActW-1:0] ACT_DEL  = 2'd1;
  localparam logic [ActW-1:0] ACT_READ = 2'd2;

  // status codes
  localparam logic [StatW-1:0] ST_OK     = 2'd0;
  localparam logic [StatW-1:0] ST_BADPOS = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY  = 2'd2;
  localparam logic [StatW-1:0] ST_FULL   = 2'd3;

  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_INS  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_ROT  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               op;
    logic [PosW-1:0]    pos;
    logic [PosW-1:0]    cnt;
    logic [DataW-1:0]   value;
  } cmd_t;

endpackage

// ----- rtl/core/pida_cell.sv -----
// ----------------------------------------------------------------------------
// pida_cell - one storage cell of the entry chain
// Holds one entry and, per the broadcast command, keeps it, loads the new
// value, or takes the word of its lower or upper neighbor or of the head.
// ----------------------------------------------------------------------------
module pida_cell (
  input  logic                          clk_i,
  input  pida_pkg::cmd_t                cmd_i,
  input  logic [pida_pkg::IdxW-1:0]     idx_i,
  input  logic [pida_pkg::DataW-1:0]    left_i,
  input  logic [pida_pkg::DataW-1:0]    right_i,
  input  logic [pida_pkg::DataW-1:0]    head_i,
  output logic [pida_pkg::DataW-1:0]    data_o
);

  logic [pida_pkg::DataW-1:0] data_q, data_d;
  logic [pida_pkg::PosW-1:0]  idx_ext;
  logic [pida_pkg::PosW-1:0]  idx_nxt;

  assign idx_ext = pida_pkg::PosW'(idx_i);
  assign idx_nxt = idx_ext + pida_pkg::PosW'(1);

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      pida_pkg::CMD_INS: begin
        if (idx_ext == cmd_i.pos) begin
          data_d = cmd_i.value;
        end else if (idx_ext > cmd_i.pos) begin
          data_d = left_i;
        end
      end
      pida_pkg::CMD_DEL: begin
        if (idx_ext >= cmd_i.pos) begin
          data_d = right_i;
        end
      end
      pida_pkg::CMD_ROT: begin
        // rotate the occupied part by one; the head wraps to the top entry
        if (idx_nxt == cmd_i.cnt) begin
          data_d = head_i;
        end else if (idx_nxt < cmd_i.cnt) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- rtl/core/positional_insert_delete_array.sv -----
// ----------------------------------------------------------------------------
// positional_insert_delete_array - ordered word array with positional edits
// Chain of cells holding up to CAPACITY signed words, plus a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken at a rising edge with start high and busy low:
//   action_i selects insert, delete or readout; position_i and value_i go
//   with it. Results come back on status_o, element_count_o, element_o and
//   last_o, each valid for exactly one cycle while valid_o is high.
//   Insert and delete shift the cells from the position upward in the same
//   edge that takes the beat; the single result appears in the next cycle and
//   busy stays low, so a new command may follow in every cycle.
//   Readout of N entries holds busy high while the occupied cells rotate by
//   one each cycle and the head cell is sent out, so results arrive one per
//   cycle, the first after the read state and the output register, with
//   last_o on the final one; the next command can be taken at the end of the
//   cycle that shows the final beat. After N rotations the order is back as
//   it was. An empty array gives a single result with status empty.
//   The receiver cannot stall; results are never held.
//   Reset clears the entry count and the sequencer; the cells keep whatever
//   they hold, and only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_insert_delete_array (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [pida_pkg::ActW-1:0]      action_i,
  input  logic [pida_pkg::PosW-1:0]      position_i,
  input  logic signed [pida_pkg::DataW-1:0] value_i,
  output logic                           valid_o,
  output logic [pida_pkg::StatW-1:0]     status_o,
  output logic [pida_pkg::PosW-1:0]      element_count_o,
  output logic signed [pida_pkg::DataW-1:0] element_o,
  output logic                           last_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                           state_q, state_d;
  logic [pida_pkg::PosW-1:0]      count_q, count_d;
  logic [pida_pkg::PosW-1:0]      rd_left_q, rd_left_d;
  logic                           valid_q, valid_d;
  logic [pida_pkg::StatW-1:0]     status_q, status_d;
  logic [pida_pkg::DataW-1:0]     elem_q, elem_d;
  logic                           last_q, last_d;
  logic                           accept;
  pida_pkg::cmd_t                 cmd;
  logic [pida_pkg::DataW-1:0]     cell_data [pida_pkg::CAPACITY];

  assign busy   = (state_q == ST_READ);
  assign accept = start && !busy;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rd_left_d = rd_left_q;
    valid_d   = 1'b0;
    status_d  = pida_pkg::ST_OK;
    elem_d    = '0;
    last_d    = 1'b1;
    cmd.op    = pida_pkg::CMD_HOLD;
    cmd.pos   = position_i;
    cmd.cnt   = count_q;
    cmd.value = value_i;

    if (state_q == ST_READ) begin
      cmd.op    = pida_pkg::CMD_ROT;
      valid_d   = 1'b1;
      elem_d    = cell_data[0];
      last_d    = (rd_left_q == pida_pkg::PosW'(1));
      rd_left_d = rd_left_q - pida_pkg::PosW'(1);
      if (last_d) begin
        state_d = ST_IDLE;
      end
    end else if (accept) begin
      valid_d = 1'b1;
      case (action_i)
        pida_pkg::ACT_INS: begin
          if (position_i > count_q) begin
            status_d = pida_pkg::ST_BADPOS;
          end else if (count_q == pida_pkg::PosW'(pida_pkg::CAPACITY)) begin
            status_d = pida_pkg::ST_FULL;
          end else begin
            cmd.op  = pida_pkg::CMD_INS;
            count_d = count_q + pida_pkg::PosW'(1);
          end
        end
        pida_pkg::ACT_DEL: begin
          if (count_q == '0) begin
            status_d = pida_pkg::ST_EMPTY;
          end else if (position_i >= count_q) begin
            status_d = pida_pkg::ST_BADPOS;
          end else begin
            cmd.op  = pida_pkg::CMD_DEL;
            count_d = count_q - pida_pkg::PosW'(1);
          end
        end
        pida_pkg::ACT_READ: begin
          if (count_q == '0) begin
            status_d = pida_pkg::ST_EMPTY;
          end else begin
            // results come from the read state, one beat per entry
            valid_d   = 1'b0;
            state_d   = ST_READ;
            rd_left_d = count_q;
          end
        end
        default: status_d = pida_pkg::ST_BADPOS;
      endcase
    end
  end

  for (genvar i = 0; i < pida_pkg::CAPACITY; i++) begin : g_cell
    logic [pida_pkg::DataW-1:0] left_w, right_w;
    if (i == 0) begin : g_lo
      assign left_w = '0;
    end else begin : g_lo
      assign left_w = cell_data[i-1];
    end
    if (i == pida_pkg::CAPACITY - 1) begin : g_hi
      assign right_w = '0;
    end else begin : g_hi
      assign right_w = cell_data[i+1];
    end
    pida_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (pida_pkg::IdxW'(i)),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rd_left_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_left_q <= rd_left_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    elem_q   <= elem_d;
    last_q   <= last_d;
  end

  assign valid_o         = valid_q;
  assign status_o        = status_q;
  assign element_count_o = count_q;
  assign element_o       = elem_q;
  assign last_o          = last_q;

  // count never runs past the capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pida_pkg::PosW'(pida_pkg::CAPACITY))
    else $error("entry count above capacity");

  // a beat without last only comes from a readout still in progress
  a_mid_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> busy)
    else $error("non-final result outside readout");

  // readout ends with the final beat on the output
  a_read_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (valid_o && last_o))
    else $error("readout ended without final beat");

  // count does not move during readout
  a_read_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> $stable(count_q))
    else $error("count changed during readout");

endmodule
